// ===== src/sha256_byte_stream_hasher_assert.svh =====
// Assertion macros used by the hasher's top-level RTL file.
`ifndef SHA256_BYTE_STREAM_HASHER_ASSERT_SVH
`define SHA256_BYTE_STREAM_HASHER_ASSERT_SVH

`ifndef SYNTH
`define SHABS_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("shabs assertion failed");
`define SHABS_NEVER(name, clk, rst_n, expr) \
    name: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("shabs forbidden condition seen");
`else
`define SHABS_ASSERT(name, clk, rst_n, prop)
`define SHABS_NEVER(name, clk, rst_n, expr)
`endif

`endif

// ===== src/shabs_pkg.sv =====
// Types, codes and constant tables of the SHA-256 byte stream hasher.
package shabs_pkg;

    typedef logic [31:0] word_t;

    localparam int unsigned ROUNDS = 64;
    localparam int unsigned HASH_WORDS = 8;
    localparam int unsigned LEN_BITS = 61;

    localparam logic [1:0] MODE_ABSORB        = 2'd0;
    localparam logic [1:0] MODE_ABSORB_FINISH = 2'd1;
    localparam logic [1:0] MODE_FINISH        = 2'd2;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_SLOT  = 6'd63;
    localparam logic [3:0] LEN_BYTES  = 4'd8;

    localparam word_t INIT_HASH [HASH_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam word_t ROUND_K [ROUNDS] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    typedef struct packed {
        logic       start;
        logic       load;
        logic [7:0] load_byte;
        logic       reinit;
    } core_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } core_stat_t;

endpackage

// ===== src/sha256_byte_stream_hasher.sv =====
// Top level of the SHA-256 byte stream hasher: byte intake, padding sequencer and digest output.
//
//  channel   direction  handshake                   payload
//  item      in         item_valid / item_ready     mode, data_byte
//  digest    out        digest_valid / digest_ready digest_word, word_index, last_word
//
// An absorbed byte is loaded into the block buffer; the 64th byte of a block starts the round
// unit, which runs 64 rounds at one per cycle and then the chaining add, after which the next
// transaction is taken.
// A finish feeds the padding bytes at one per cycle, pausing while each of its one or two
// blocks is compressed, then offers the eight digest words, one per transaction. item_ready
// is low while a block is compressed, and from a finish until the last digest word is taken.
// Reset returns the chaining value to the initial hash value and clears the counts.
`include "sha256_byte_stream_hasher_assert.svh"

module sha256_byte_stream_hasher (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_ready,
    input  logic [1:0]  mode,
    input  logic [7:0]  data_byte,
    output logic        digest_valid,
    input  logic        digest_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_COMP = 2'd1;
    localparam logic [1:0] ST_PAD  = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    logic [1:0]                                   state_reg;
    logic [1:0]                                   state_next;
    logic [5:0]                                   fill_reg;
    logic [5:0]                                   fill_next;
    logic [shabs_pkg::LEN_BITS-1:0]               length_reg;
    logic [shabs_pkg::LEN_BITS-1:0]               length_next;
    logic                                         fin_reg;
    logic                                         fin_next;
    logic                                         marker_reg;
    logic                                         marker_next;
    logic [3:0]                                   len_cnt_reg;
    logic [3:0]                                   len_cnt_next;
    logic [2:0]                                   out_idx_reg;
    logic [2:0]                                   out_idx_next;
    logic                                         put_en;
    logic [7:0]                                   put_byte;
    logic                                         len_phase;
    logic                                         item_take;
    logic                                         digest_take;
    shabs_pkg::core_ctrl_t                        core_ctrl;
    shabs_pkg::core_stat_t                        core_stat;
    shabs_pkg::word_t [shabs_pkg::HASH_WORDS-1:0] chain;

    shabs_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (core_ctrl),
        .stat  (core_stat),
        .chain (chain)
    );

    assign item_ready = (state_reg == ST_IDLE);
    assign item_take = item_valid && item_ready;
    assign digest_valid = (state_reg == ST_OUT);
    assign digest_take = digest_valid && digest_ready;
    assign len_phase = marker_reg
        && ((len_cnt_reg != 4'd0) || (fill_reg == shabs_pkg::LEN_OFFSET));

    always_comb
    begin
        state_next = state_reg;
        fin_next = fin_reg;
        marker_next = marker_reg;
        len_cnt_next = len_cnt_reg;
        out_idx_next = out_idx_reg;
        length_next = length_reg;
        put_en = 1'b0;
        put_byte = data_byte;
        core_ctrl.reinit = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (item_take)
                begin
                    if ((mode == shabs_pkg::MODE_ABSORB)
                        || (mode == shabs_pkg::MODE_ABSORB_FINISH))
                    begin
                        put_en = 1'b1;
                        length_next = length_reg
                            + {{(shabs_pkg::LEN_BITS-1){1'b0}}, 1'b1};
                    end
                    if ((mode == shabs_pkg::MODE_ABSORB_FINISH)
                        || (mode == shabs_pkg::MODE_FINISH))
                    begin
                        fin_next = 1'b1;
                        marker_next = 1'b0;
                        len_cnt_next = '0;
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                put_en = 1'b1;
                if (!marker_reg)
                begin
                    put_byte = shabs_pkg::PAD_MARKER;
                    marker_next = 1'b1;
                end
                else if (len_phase)
                begin
                    put_byte = length_reg[shabs_pkg::LEN_BITS-1 -: 8];
                    length_next = {length_reg[shabs_pkg::LEN_BITS-9:0], 8'd0};
                    len_cnt_next = len_cnt_reg + 4'd1;
                end
                else
                begin
                    put_byte = 8'd0;
                end
            end
            ST_COMP:
            begin
                if (core_stat.done)
                begin
                    if (!fin_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (len_cnt_reg == shabs_pkg::LEN_BYTES)
                    begin
                        state_next = ST_OUT;
                        out_idx_next = '0;
                    end
                    else
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_OUT:
            begin
                if (digest_take)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (out_idx_reg == 3'(shabs_pkg::HASH_WORDS - 1))
                    begin
                        core_ctrl.reinit = 1'b1;
                        fin_next = 1'b0;
                        length_next = '0;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        fill_next = put_en ? fill_reg + 6'd1 : fill_reg;
        core_ctrl.load = put_en;
        core_ctrl.load_byte = put_byte;
        core_ctrl.start = put_en && (fill_reg == shabs_pkg::LAST_SLOT);
        if (core_ctrl.start)
        begin
            state_next = ST_COMP;
        end
        if (core_ctrl.reinit)
        begin
            fill_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            fill_reg <= '0;
            length_reg <= '0;
            fin_reg <= 1'b0;
            marker_reg <= 1'b0;
            len_cnt_reg <= '0;
            out_idx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg <= fill_next;
            length_reg <= length_next;
            fin_reg <= fin_next;
            marker_reg <= marker_next;
            len_cnt_reg <= len_cnt_next;
            out_idx_reg <= out_idx_next;
        end
    end

    assign digest_word = chain[out_idx_reg];
    assign word_index = out_idx_reg;
    assign last_word = (out_idx_reg == 3'(shabs_pkg::HASH_WORDS - 1));

    `SHABS_ASSERT(a_busy_in_comp, clk, rst_n, core_stat.busy |-> (state_reg == ST_COMP))
    `SHABS_ASSERT(a_out_block_empty, clk, rst_n, digest_valid |-> (fill_reg == 6'd0))
    `SHABS_NEVER(a_len_cnt_range, clk, rst_n, len_cnt_reg > shabs_pkg::LEN_BYTES)
    `SHABS_ASSERT(a_last_then_ready, clk, rst_n, (digest_take && last_word) |=> item_ready)

endmodule

// ===== src/shabs_core.sv =====
// Block buffer, message schedule and iterative SHA-256 round unit with the chaining value.
module shabs_core (
    input  logic                                         clk,
    input  logic                                         rst_n,
    input  shabs_pkg::core_ctrl_t                        ctrl,
    output shabs_pkg::core_stat_t                        stat,
    output shabs_pkg::word_t [shabs_pkg::HASH_WORDS-1:0] chain
);

    localparam logic [5:0] LAST_ROUND = 6'(shabs_pkg::ROUNDS - 1);

    function automatic shabs_pkg::word_t big_sigma0(shabs_pkg::word_t v);
        return {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
    endfunction

    function automatic shabs_pkg::word_t big_sigma1(shabs_pkg::word_t v);
        return {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
    endfunction

    function automatic shabs_pkg::word_t small_sigma0(shabs_pkg::word_t v);
        return {v[6:0], v[31:7]} ^ {v[17:0], v[31:18]} ^ {3'b000, v[31:3]};
    endfunction

    function automatic shabs_pkg::word_t small_sigma1(shabs_pkg::word_t v);
        return {v[16:0], v[31:17]} ^ {v[18:0], v[31:19]} ^ {10'd0, v[31:10]};
    endfunction

    logic                                         busy_reg;
    logic                                         busy_next;
    logic                                         add_reg;
    logic                                         add_next;
    logic [5:0]                                   round_reg;
    logic [5:0]                                   round_next;
    shabs_pkg::word_t [shabs_pkg::HASH_WORDS-1:0] chain_reg;
    shabs_pkg::word_t [shabs_pkg::HASH_WORDS-1:0] work_reg;
    shabs_pkg::word_t [15:0]                      win_reg;
    logic [511:0]                                 win_ext;
    shabs_pkg::word_t                             t1;
    shabs_pkg::word_t                             t2;
    shabs_pkg::word_t                             ch;
    shabs_pkg::word_t                             maj;
    shabs_pkg::word_t                             sched_word;

    // The window holds w[t] in its top word; bytes shift in at the bottom.
    assign win_ext = {win_reg[15][23:0], win_reg[14:0], ctrl.load_byte};

    always_comb
    begin
        ch = (work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]);
        maj = (work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
            ^ (work_reg[1] & work_reg[2]);
        t1 = work_reg[7] + big_sigma1(work_reg[4]) + ch
            + shabs_pkg::ROUND_K[round_reg] + win_reg[15];
        t2 = big_sigma0(work_reg[0]) + maj;
        sched_word = small_sigma1(win_reg[1]) + win_reg[6]
            + small_sigma0(win_reg[14]) + win_reg[15];
    end

    always_comb
    begin
        busy_next = busy_reg;
        add_next = 1'b0;
        round_next = round_reg;
        if (ctrl.start)
        begin
            busy_next = 1'b1;
            round_next = '0;
        end
        else if (busy_reg)
        begin
            round_next = round_reg + 6'd1;
            if (round_reg == LAST_ROUND)
            begin
                busy_next = 1'b0;
                add_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            add_reg <= 1'b0;
            round_reg <= '0;
            for (int i = 0; i < shabs_pkg::HASH_WORDS; i++)
            begin
                chain_reg[i] <= shabs_pkg::INIT_HASH[i];
            end
        end
        else
        begin
            busy_reg <= busy_next;
            add_reg <= add_next;
            round_reg <= round_next;
            if (ctrl.reinit)
            begin
                for (int i = 0; i < shabs_pkg::HASH_WORDS; i++)
                begin
                    chain_reg[i] <= shabs_pkg::INIT_HASH[i];
                end
            end
            else if (add_reg)
            begin
                for (int i = 0; i < shabs_pkg::HASH_WORDS; i++)
                begin
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.start)
        begin
            work_reg <= chain_reg;
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[6:4], work_reg[3] + t1, work_reg[2:0], t1 + t2};
        end
        if (ctrl.load)
        begin
            win_reg <= win_ext;
        end
        else if (busy_reg)
        begin
            win_reg <= {win_reg[14:0], sched_word};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = add_reg;
    assign chain = chain_reg;

endmodule
